// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdfsm check failed");

// Next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdfsm check failed");

`endif

// ===== hdl/tdfsm_pkg.sv =====
// Shared types and codes of the table-driven state machine engine.
// Used by the top level and by its checker; depends on nothing.
package tdfsm_pkg;

  localparam int STATE_W = 4;
  localparam int EVENT_W = 4;
  localparam int ENTRY_W = 2 * STATE_W + EVENT_W;

  // Request types
  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_POST     = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_APPLY    = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QFULL    = 3'd1,
    ST_QEMPTY   = 3'd2,
    ST_TFULL    = 3'd3,
    ST_REQUEUED = 3'd4,
    ST_DROPPED  = 3'd5
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RING = 2'd1,
    S_SCAN = 2'd2
  } fsm_e;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_INIT  = 2'd0;
  localparam logic [1:0] REG_FLUSH = 2'd1;
  localparam logic [1:0] REG_ENTRY = 2'd2;
  localparam logic [1:0] REG_EXIT  = 2'd3;

endpackage

// ===== hdl/tdfsm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the transition table and the event ring.
module tdfsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/table_driven_fsm_with_event_queue.sv =====
// Top level of the table-driven state machine engine with a pending-event ring.
// Depends on tdfsm_pkg and tdfsm_ram (transition table and event ring memories).
//
// A request is taken when start is high and busy is low; its one result shows on
// the result ports for a single cycle with done_o high and cannot be held off.
// Adding a transition, posting an event and dispatching from an empty ring give
// their result in the cycle after the request, with busy staying low. Applying an
// event scans the loaded transitions one per cycle through the table memory's
// read port, examining from 1 up to NUM_TRANSITIONS entries until one matches;
// with an empty table its result comes in the cycle after the request. A dispatch
// first reads its event from the ring memory, then scans the same way.
module table_driven_fsm_with_event_queue
  import tdfsm_pkg::*;
#(
  parameter int NUM_TRANSITIONS = 32,
  parameter int QUEUE_DEPTH     = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request channel
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   req_type_i,
  input  logic [3:0]   from_state_i,
  input  logic [3:0]   event_code_i,
  input  logic [3:0]   to_state_i,
  // result channel
  output logic         done_o,
  output logic [2:0]   status_o,
  output logic [3:0]   current_state_o,
  output logic [3:0]   handled_event_o,
  output logic         transitioned_o,
  output logic         exit_fire_o,
  output logic [3:0]   exited_state_o,
  output logic         entry_fire_o,
  output logic [3:0]   entered_state_o,
  output logic [3:0]   queue_count_o,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int TAW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
  localparam int TCW = $clog2(NUM_TRANSITIONS + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QAW:0]   QD_W   = (QAW + 1)'(QUEUE_DEPTH);
  localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [TCW-1:0] T_FULL = TCW'(NUM_TRANSITIONS);

  // Configuration registers
  logic [STATE_W-1:0] init_q;
  logic               flush_q;
  logic [15:0]        entry_mask_q;
  logic [15:0]        exit_mask_q;
  logic               cfg_we;
  logic [1:0]         cfg_idx;

  // Engine state
  fsm_e               state_q, state_d;
  logic [STATE_W-1:0] active_q, active_d;
  logic [TCW-1:0]     tcount_q, tcount_d;
  logic [TCW-1:0]     idx_q, idx_d;
  logic [QAW-1:0]     wr_q, wr_d;
  logic [QAW-1:0]     rd_q, rd_d;
  logic [EVENT_W-1:0] ev_q, ev_d;
  logic [EVENT_W-1:0] cur_ev;
  logic               scan_go;
  logic               unmatched;

  // Memory ports
  logic               tbl_we;
  logic [TAW-1:0]     tbl_waddr, tbl_raddr;
  logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
  logic               ring_we;
  logic [QAW-1:0]     ring_waddr, ring_raddr;
  logic [EVENT_W-1:0] ring_wdata, ring_rdata;

  // Table entry fields
  logic [STATE_W-1:0] ent_from, ent_to;
  logic [EVENT_W-1:0] ent_ev;

  // Ring occupancy
  logic [QAW-1:0]     ring_cnt;
  logic               ring_full;

  // Result staging and output registers
  logic               res_valid;
  status_e            res_status;
  logic [EVENT_W-1:0] res_event;
  logic               res_trans, res_exit, res_entry;
  logic [STATE_W-1:0] res_exited, res_entered;
  logic               done_q;
  status_e            status_q;
  logic [STATE_W-1:0] cur_state_q, exited_q, entered_q;
  logic [EVENT_W-1:0] handled_q;
  logic               trans_q, exit_q, entry_q;
  logic [3:0]         qcount_q;

  function automatic logic [QAW-1:0] ring_next(input logic [QAW-1:0] i);
    ring_next = (i == Q_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [QAW-1:0] ring_count(input logic [QAW-1:0] w,
                                                input logic [QAW-1:0] r);
    if (w >= r) begin
      ring_count = w - r;
    end else begin
      ring_count = QAW'(QD_W - {1'b0, r} + {1'b0, w});
    end
  endfunction

  // Memories
  tdfsm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TRANSITIONS)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  tdfsm_ram #(.WIDTH(EVENT_W), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign ent_from = tbl_rdata[ENTRY_W-1 -: STATE_W];
  assign ent_ev   = tbl_rdata[STATE_W +: EVENT_W];
  assign ent_to   = tbl_rdata[STATE_W-1:0];

  assign ring_cnt  = ring_count(wr_q, rd_q);
  assign ring_full = (ring_cnt == Q_LAST);

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_INIT:  prdata = 32'(init_q);
      REG_FLUSH: prdata = 32'(flush_q);
      REG_ENTRY: prdata = 32'(entry_mask_q);
      REG_EXIT:  prdata = 32'(exit_mask_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q       <= '0;
      flush_q      <= 1'b0;
      entry_mask_q <= '0;
      exit_mask_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INIT:  init_q       <= pwdata[STATE_W-1:0];
        REG_FLUSH: flush_q      <= pwdata[0];
        REG_ENTRY: entry_mask_q <= pwdata[15:0];
        REG_EXIT:  exit_mask_q  <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Sequencer: request decode, table scan, requeue
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    tcount_d    = tcount_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    cur_ev      = ev_q;
    scan_go     = 1'b0;
    unmatched   = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = tcount_q[TAW-1:0];
    tbl_wdata   = {from_state_i, event_code_i, to_state_i};
    tbl_raddr   = '0;
    ring_we     = 1'b0;
    ring_waddr  = wr_q;
    ring_wdata  = event_code_i;
    ring_raddr  = rd_q;
    res_valid   = 1'b0;
    res_status  = ST_OK;
    res_event   = '0;
    res_trans   = 1'b0;
    res_exit    = 1'b0;
    res_exited  = '0;
    res_entry   = 1'b0;
    res_entered = '0;

    // writing the initial state also moves the machine there
    if (cfg_we && cfg_idx == REG_INIT) begin
      active_d = pwdata[STATE_W-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_e'(req_type_i))
            REQ_ADD: begin
              res_valid = 1'b1;
              if (tcount_q == T_FULL) begin
                res_status = ST_TFULL;
              end else begin
                tbl_we   = 1'b1;
                tcount_d = tcount_q + 1'b1;
              end
            end
            REQ_POST: begin
              res_valid = 1'b1;
              if (ring_full) begin
                res_status = ST_QFULL;
              end else begin
                ring_we = 1'b1;
                wr_d    = ring_next(wr_q);
              end
            end
            REQ_DISPATCH: begin
              if (ring_cnt == '0) begin
                res_valid  = 1'b1;
                res_status = ST_QEMPTY;
              end else begin
                rd_d    = ring_next(rd_q);
                state_d = S_RING;
              end
            end
            REQ_APPLY: begin
              cur_ev  = event_code_i;
              scan_go = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RING: begin
        cur_ev  = ring_rdata;
        scan_go = 1'b1;
      end
      S_SCAN: begin
        if (ent_from == active_q && ent_ev == ev_q) begin
          res_valid   = 1'b1;
          res_event   = ev_q;
          res_trans   = (ent_to != ent_from);
          res_exit    = exit_mask_q[ent_from];
          res_exited  = ent_from;
          res_entry   = entry_mask_q[ent_to];
          res_entered = ent_to;
          active_d    = ent_to;
          state_d     = S_IDLE;
        end else if (idx_q + 1'b1 == tcount_q) begin
          unmatched = 1'b1;
        end else begin
          idx_d     = idx_q + 1'b1;
          tbl_raddr = idx_d[TAW-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase

    // start a scan from the first entry
    if (scan_go) begin
      if (tcount_q == '0) begin
        unmatched = 1'b1;
      end else begin
        idx_d     = '0;
        tbl_raddr = '0;
        state_d   = S_SCAN;
      end
    end

    // no entry matched: drop or put back on the ring
    if (unmatched) begin
      res_valid = 1'b1;
      res_event = cur_ev;
      state_d   = S_IDLE;
      if (flush_q) begin
        res_status = ST_DROPPED;
      end else if (ring_full) begin
        res_status = ST_QFULL;
      end else begin
        ring_we    = 1'b1;
        ring_wdata = cur_ev;
        wr_d       = ring_next(wr_q);
        res_status = ST_REQUEUED;
      end
    end

    ev_d = cur_ev;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      tcount_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      tcount_q <= tcount_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      done_q   <= res_valid;
    end
  end

  // Scan position, event under work and result payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ev_q  <= ev_d;
    if (res_valid) begin
      status_q    <= res_status;
      cur_state_q <= active_d;
      handled_q   <= res_event;
      trans_q     <= res_trans;
      exit_q      <= res_exit;
      exited_q    <= res_exited;
      entry_q     <= res_entry;
      entered_q   <= res_entered;
      qcount_q    <= 4'(ring_count(wr_d, rd_d));
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign current_state_o = cur_state_q;
  assign handled_event_o = handled_q;
  assign transitioned_o  = trans_q;
  assign exit_fire_o     = exit_q;
  assign exited_state_o  = exited_q;
  assign entry_fire_o    = entry_q;
  assign entered_state_o = entered_q;
  assign queue_count_o   = qcount_q;

endmodule

// ===== hdl/tdfsm_checker.sv =====
// Port-level checker for the state machine engine, bound to the top level.
// Depends on tdfsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tdfsm_checker
  import tdfsm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [3:0] current_state_o,
  input logic       transitioned_o,
  input logic       exit_fire_o,
  input logic [3:0] exited_state_o,
  input logic       entry_fire_o,
  input logic [3:0] entered_state_o
);

  // a taken request either finishes at once or keeps the engine busy
  `CHK_NEXT(a_req_progress, clk_i, rst_ni, start && !busy, done_o || busy)

  // a result marks the engine idle again
  `CHK_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // a real transition lands in the entered state
  `CHK_IMPL(a_trans_state, clk_i, rst_ni, done_o && transitioned_o,
            entered_state_o != exited_state_o && current_state_o == entered_state_o)

  // no action pulses without a match
  `CHK_IMPL(a_no_fire, clk_i, rst_ni, done_o && status_o != ST_OK,
            !transitioned_o && !exit_fire_o && !entry_fire_o)

endmodule

bind table_driven_fsm_with_event_queue tdfsm_checker u_tdfsm_checker (.*);
